// ===== sv/lafe_pkg.sv =====
// ----------------------------------------------------------------------------
// lafe_pkg
// Types and constants shared by the addressable LED frame encoder.
// ----------------------------------------------------------------------------
package lafe_pkg;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 10;
    localparam int COLOR_W = 8;
    localparam int PIXEL_W = 3 * COLOR_W;
    localparam int TICKS_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SHOW  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_SLOTS = 2'd3;

    // register reset values
    localparam logic [7:0]         RST_MAX_CHANNEL = 8'd255;
    localparam logic [TICKS_W-1:0] RST_ONE_TICKS   = 7'd51;
    localparam logic [TICKS_W-1:0] RST_ZERO_TICKS  = 7'd26;
    localparam logic [7:0]         RST_LATCH_SLOTS = 8'd80;

    // rounding offset for the channel scale (v*max+127)/255
    localparam logic [15:0] SCALE_ROUND = 16'd127;

    // channel order on the wire: green, red, blue
    localparam logic [1:0] CH_GREEN = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [2:0] BIT_MSB = 3'd7;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DATA,
        PH_TRAIL
    } t_phase;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_FIN
    } t_state;

endpackage

// ===== sv/lafe_ram.sv =====
// ----------------------------------------------------------------------------
// lafe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lafe_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/addressable_led_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder
// RGB pixel store and PWM slot generator for a single-wire LED strip.
// ----------------------------------------------------------------------------
// One item is in work at a time; from its input transfer to its result it
// passes the store read, the registered channel multiply, and the
// finish step that updates state and loads the output register. A new item
// is taken only after the finish step, which waits while the result
// register still holds an untaken result. A clear command while no frame
// is being sent first sweeps the store to zero one entry a cycle. After
// reset the same sweep runs with s_axis_tready low; configuration writes
// are taken at any time.
module addressable_led_frame_encoder
    import lafe_pkg::*;
#(
    parameter int LED_COUNT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // index, red, green, blue
    input  logic [CMD_W-1:0]      s_axis_tuser,  // command
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_red, read_green, read_blue, slot_value, frame_done, busy_res, rejected
    output logic [39:0]           m_axis_tdata,
    output logic [1:0]            m_axis_tuser   // read_valid, slot_valid
);

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [AW-1:0]      LAST_ADDR = AW'(LED_COUNT - 1);
    localparam logic [INDEX_W:0]   COUNT_EXT = (INDEX_W + 1)'(LED_COUNT);

    // configuration
    logic [7:0]         r_max_chan;
    logic [TICKS_W-1:0] r_one_ticks;
    logic [TICKS_W-1:0] r_zero_ticks;
    logic [7:0]         r_latch_slots;

    // control
    t_state r_state, n_state;
    logic   r_sweep_cmd, n_sweep_cmd;
    logic [AW-1:0] r_sweep_addr, n_sweep_addr;

    // frame state
    logic          r_sending, n_sending;
    logic          r_changed, n_changed;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_latch_cnt, n_latch_cnt;
    logic [AW-1:0] r_pix_ptr, n_pix_ptr;
    logic [1:0]    r_chan_ptr, n_chan_ptr;
    logic [2:0]    r_bit_ptr, n_bit_ptr;

    // item in work
    logic [CMD_W-1:0]   r_cmd;
    logic [INDEX_W-1:0] r_idx;
    logic [COLOR_W-1:0] r_red, r_grn, r_blu;
    logic [15:0]        r_prod, n_prod;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_rd_valid, n_rd_valid;
    logic [PIXEL_W-1:0] r_rd_pix, n_rd_pix;
    logic               r_slot_valid, n_slot_valid;
    logic [TICKS_W-1:0] r_slot_value, n_slot_value;
    logic               r_done, n_done;
    logic               r_busy, n_busy;
    logic               r_rej, n_rej;

    // store port
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [PIXEL_W-1:0] mem_wdata, mem_rdata;

    logic               in_xfer;
    logic               out_free;
    logic               idx_in_range;
    logic [PIXEL_W-1:0] item_pix;
    logic [COLOR_W-1:0] chan_byte;
    logic [16:0]        quo_sum;
    logic [7:0]         scaled;
    logic [8:0]         trail_next;
    t_phase             eff_phase;
    logic [7:0]         eff_cnt;
    logic               tick_done;

    assign in_xfer      = s_axis_tvalid && s_axis_tready;
    assign out_free     = !r_out_valid || m_axis_tready;
    assign idx_in_range = ({1'b0, r_idx} < COUNT_EXT);
    assign item_pix     = {r_red, r_grn, r_blu};
    assign s_axis_tready = (r_state == ST_IDLE);

    lafe_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LED_COUNT),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chan    <= RST_MAX_CHANNEL;
            r_one_ticks   <= RST_ONE_TICKS;
            r_zero_ticks  <= RST_ZERO_TICKS;
            r_latch_slots <= RST_LATCH_SLOTS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_CHANNEL: r_max_chan    <= i_cfg_data;
                REG_ONE_TICKS:   r_one_ticks   <= i_cfg_data[TICKS_W-1:0];
                REG_ZERO_TICKS:  r_zero_ticks  <= i_cfg_data[TICKS_W-1:0];
                REG_LATCH_SLOTS: r_latch_slots <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_cmd  <= 1'b0;
            r_sweep_addr <= '0;
            r_sending    <= 1'b0;
            r_changed    <= 1'b1;
            r_phase      <= PH_LEAD;
            r_latch_cnt  <= '0;
            r_pix_ptr    <= '0;
            r_chan_ptr   <= CH_GREEN;
            r_bit_ptr    <= BIT_MSB;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_cmd  <= n_sweep_cmd;
            r_sweep_addr <= n_sweep_addr;
            r_sending    <= n_sending;
            r_changed    <= n_changed;
            r_phase      <= n_phase;
            r_latch_cnt  <= n_latch_cnt;
            r_pix_ptr    <= n_pix_ptr;
            r_chan_ptr   <= n_chan_ptr;
            r_bit_ptr    <= n_bit_ptr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= s_axis_tuser;
            r_idx <= s_axis_tdata[9:0];
            r_red <= s_axis_tdata[17:10];
            r_grn <= s_axis_tdata[25:18];
            r_blu <= s_axis_tdata[33:26];
        end
        r_prod       <= n_prod;
        r_rd_valid   <= n_rd_valid;
        r_rd_pix     <= n_rd_pix;
        r_slot_valid <= n_slot_valid;
        r_slot_value <= n_slot_value;
        r_done       <= n_done;
        r_busy       <= n_busy;
        r_rej        <= n_rej;
    end

    // channel pick and scale datapath
    always_comb begin
        case (r_chan_ptr)
            CH_GREEN: chan_byte = mem_rdata[15:8];
            CH_RED:   chan_byte = mem_rdata[23:16];
            default:  chan_byte = mem_rdata[7:0];
        endcase
        // x/255 == (x + (x>>8) + 1) >> 8 for x below 65535
        quo_sum = {1'b0, r_prod} + {9'd0, r_prod[15:8]} + 17'd1;
        scaled  = quo_sum[15:8];
    end

    always_comb begin
        n_state      = r_state;
        n_sweep_cmd  = r_sweep_cmd;
        n_sweep_addr = r_sweep_addr;
        n_sending    = r_sending;
        n_changed    = r_changed;
        n_phase      = r_phase;
        n_latch_cnt  = r_latch_cnt;
        n_pix_ptr    = r_pix_ptr;
        n_chan_ptr   = r_chan_ptr;
        n_bit_ptr    = r_bit_ptr;
        n_prod       = r_prod;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_rd_valid   = r_rd_valid;
        n_rd_pix     = r_rd_pix;
        n_slot_valid = r_slot_valid;
        n_slot_value = r_slot_value;
        n_done       = r_done;
        n_busy       = r_busy;
        n_rej        = r_rej;

        mem_we    = 1'b0;
        mem_waddr = r_sweep_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = (s_axis_tuser == CMD_TICK) ? r_pix_ptr : s_axis_tdata[AW-1:0];

        eff_phase  = r_phase;
        eff_cnt    = r_latch_cnt;
        trail_next = {1'b0, r_latch_cnt} + 9'd1;
        tick_done  = 1'b0;

        case (r_state)
            ST_SWEEP: begin
                mem_we       = 1'b1;
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (r_sweep_addr == LAST_ADDR) begin
                    n_sweep_addr = '0;
                    n_sweep_cmd  = 1'b0;
                    n_state      = r_sweep_cmd ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    mem_re = 1'b1;
                    if (s_axis_tuser == CMD_CLEAR && !r_sending) begin
                        n_sweep_cmd = 1'b1;
                        n_state     = ST_SWEEP;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_prod  = ({8'd0, chan_byte} * {8'd0, r_max_chan}) + SCALE_ROUND;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_rd_valid   = 1'b0;
                    n_rd_pix     = '0;
                    n_slot_valid = 1'b0;
                    n_slot_value = '0;
                    n_done       = 1'b0;
                    n_rej        = 1'b0;
                    n_state      = ST_IDLE;
                    case (r_cmd)
                        CMD_WRITE: begin
                            if (r_sending) begin
                                n_rej = 1'b1;
                            end else if (idx_in_range && mem_rdata != item_pix) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_idx[AW-1:0];
                                mem_wdata = item_pix;
                                n_changed = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (idx_in_range) begin
                                n_rd_valid = 1'b1;
                                n_rd_pix   = mem_rdata;
                            end
                        end
                        CMD_SHOW: begin
                            if (!r_sending && r_changed) begin
                                n_sending   = 1'b1;
                                n_changed   = 1'b0;
                                n_phase     = PH_LEAD;
                                n_latch_cnt = '0;
                                n_pix_ptr   = '0;
                                n_chan_ptr  = CH_GREEN;
                                n_bit_ptr   = BIT_MSB;
                            end
                        end
                        CMD_TICK: begin
                            if (r_sending) begin
                                n_slot_valid = 1'b1;
                                // leading latch already complete: move to data now
                                if (r_phase == PH_LEAD && r_latch_cnt >= r_latch_slots) begin
                                    eff_phase = PH_DATA;
                                    eff_cnt   = '0;
                                end
                                n_phase     = eff_phase;
                                n_latch_cnt = eff_cnt;
                                case (eff_phase)
                                    PH_LEAD: begin
                                        n_latch_cnt = eff_cnt + 8'd1;
                                    end
                                    PH_DATA: begin
                                        n_slot_value = scaled[r_bit_ptr] ? r_one_ticks
                                                                         : r_zero_ticks;
                                        if (r_bit_ptr != 3'd0) begin
                                            n_bit_ptr = r_bit_ptr - 3'd1;
                                        end else begin
                                            n_bit_ptr = BIT_MSB;
                                            if (r_chan_ptr != CH_BLUE) begin
                                                n_chan_ptr = r_chan_ptr + 2'd1;
                                            end else begin
                                                n_chan_ptr = CH_GREEN;
                                                n_pix_ptr  = r_pix_ptr + AW'(1);
                                                if (r_pix_ptr == LAST_ADDR) begin
                                                    n_pix_ptr   = '0;
                                                    n_phase     = PH_TRAIL;
                                                    n_latch_cnt = '0;
                                                    tick_done   = (r_latch_slots == 8'd0);
                                                end
                                            end
                                        end
                                    end
                                    default: begin
                                        if (trail_next >= {1'b0, r_latch_slots}) begin
                                            tick_done = 1'b1;
                                        end else begin
                                            n_latch_cnt = trail_next[7:0];
                                        end
                                    end
                                endcase
                                if (tick_done) begin
                                    n_done      = 1'b1;
                                    n_sending   = 1'b0;
                                    n_phase     = PH_LEAD;
                                    n_latch_cnt = '0;
                                    n_pix_ptr   = '0;
                                    n_chan_ptr  = CH_GREEN;
                                    n_bit_ptr   = BIT_MSB;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            // store already swept when not sending
                            if (r_sending) begin
                                n_rej = 1'b1;
                            end else begin
                                n_changed = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    n_busy = n_sending;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_slot_valid, r_rd_valid};
    assign m_axis_tdata  = {6'd0, r_rej, r_busy, r_done, r_slot_value,
                            r_rd_pix[7:0], r_rd_pix[15:8], r_rd_pix[23:16]};

    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[31]) |-> !m_axis_tdata[32])
        else $error("frame_done reported while still busy");

    a_reject_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33]) |-> (m_axis_tuser == 2'b00))
        else $error("rejected item carries read or slot data");

    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !s_axis_tready)
        else $error("input taken during store sweep");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_ptr <= LAST_ADDR)
        else $error("pixel pointer beyond strip");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_READ || r_state == ST_SWEEP))
        else $error("accepted item not started");

    a_idle_when_not_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_phase == PH_LEAD && r_latch_cnt == 8'd0))
        else $error("frame state left over while idle");

endmodule
